>>> rtl/scpa_pkg.sv
// Package: types, widths, status codes and register indexes of the size class pool allocator.
`timescale 1ns / 1ps
package scpa_pkg;

  localparam int NUM_CLASSES  = 4;
  localparam int MAX_SLOTS    = 16;
  localparam int HEADER_BYTES = 32;

  localparam int CLS_W  = 2;
  localparam int SLOT_W = 4;
  localparam int SIZE_W = 16;
  localparam int CNT_W  = 5;
  localparam int OFF_W  = 23;
  localparam int ST_W   = 2;
  localparam int IDX_W  = 3;
  localparam int LIM_W  = MAX_SLOTS + 1;

  typedef logic [ST_W-1:0]      status_t;
  typedef logic [MAX_SLOTS-1:0] slot_map_t;
  typedef logic [SIZE_W-1:0]    size_t;
  typedef logic [CNT_W-1:0]     count_t;
  typedef logic [OFF_W-1:0]     offset_t;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NOMATCH = 2'd1;
  localparam status_t ST_FULL    = 2'd2;
  localparam status_t ST_BADFREE = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [IDX_W-1:0] REG_SIZE_BASE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_COUNT_BASE = 3'd4;

  typedef struct packed {
    logic             func;
    status_t          status;
    logic [CLS_W-1:0]  cls;
    logic [SLOT_W-1:0] slot;
  } grant_t;

endpackage

>>> rtl/size_class_pool_allocator_core.sv
// Top level: size class pool allocator with registered decision and offset stages.
//
// Usage: a transaction enters on start while busy is low; busy is always low, so one
// allocate or free request may enter in every cycle. in_func selects allocate (match
// in_req_size exactly against the enabled size classes, take the lowest free slot) or
// free (clear the used mark of in_free_class / in_free_slot).
// Each request gives exactly one result on out_status, out_got_class, out_got_slot and
// out_user_offset, marked by out_valid for one cycle, after the decision and offset
// stages. The sustained rate is one request per cycle: the used bitmaps are read and
// updated in the single decision stage, so each request sees the effect of the one
// before it. The byte offset is formed in the following stage from per-class region
// sizes held in registers.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes sizes at indexes 0..3
// and block counts at indexes 4..7; write it only while no request is in flight.
// Reset (rst_n low, synchronous) clears all sizes, counts and used bitmaps and drops
// any request in flight. The receiver cannot stall; results are never held.
`timescale 1ns / 1ps
module size_class_pool_allocator_core
  import scpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_func,
  input  logic [SIZE_W-1:0] in_req_size,
  input  logic [CLS_W-1:0]  in_free_class,
  input  logic [SLOT_W-1:0] in_free_slot,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0] cfg_wdata,
  output logic              out_valid,
  output logic [ST_W-1:0]   out_status,
  output logic [CLS_W-1:0]  out_got_class,
  output logic [SLOT_W-1:0] out_got_slot,
  output logic [OFF_W-1:0]  out_user_offset
);

  size_t     size_r  [NUM_CLASSES];
  count_t    count_r [NUM_CLASSES];
  slot_map_t used_r  [NUM_CLASSES];
  slot_map_t used_nxt[NUM_CLASSES];
  offset_t   prod_r  [NUM_CLASSES];
  count_t    eff     [NUM_CLASSES];
  slot_map_t lim     [NUM_CLASSES];

  logic              in_vld_r;
  logic              in_func_r;
  logic [SIZE_W-1:0] in_req_size_r;
  logic [CLS_W-1:0]  in_free_class_r;
  logic [SLOT_W-1:0] in_free_slot_r;

  logic   s1_vld_r;
  grant_t grant_r;
  grant_t grant_nxt;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [CLS_W-1:0]  out_got_class_r;
  logic [SLOT_W-1:0] out_got_slot_r;
  offset_t           out_user_offset_r;

  logic              hit;
  logic [CLS_W-1:0]  hit_cls;
  slot_map_t         open_map;
  logic [SLOT_W-1:0] open_slot;
  logic              free_bad;
  offset_t           base;
  offset_t           stride;
  offset_t           user_off;

  assign busy = 1'b0;

  // Configuration registers and per-class region sizes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        size_r[c]  <= '0;
        count_r[c] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index < REG_COUNT_BASE) begin
        size_r[CLS_W'(cfg_index - REG_SIZE_BASE)] <= cfg_wdata;
      end else begin
        count_r[CLS_W'(cfg_index - REG_COUNT_BASE)] <= cfg_wdata[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    logic [LIM_W-1:0] wide;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (size_r[c] == '0) begin
        eff[c] = '0;
      end else if (count_r[c] > CNT_W'(MAX_SLOTS)) begin
        eff[c] = CNT_W'(MAX_SLOTS);
      end else begin
        eff[c] = count_r[c];
      end
      wide   = (LIM_W'(1) << eff[c]) - LIM_W'(1);
      lim[c] = wide[MAX_SLOTS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      prod_r[c] <= OFF_W'(eff[c]) * (OFF_W'(size_r[c]) + OFF_W'(HEADER_BYTES));
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_func_r       <= in_func;
      in_req_size_r   <= in_req_size;
      in_free_class_r <= in_free_class;
      in_free_slot_r  <= in_free_slot;
    end
  end

  // Decision stage: class match, slot search, bitmap update
  always_comb begin
    hit     = 1'b0;
    hit_cls = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (size_r[c] != '0 && size_r[c] == in_req_size_r) begin
        hit     = 1'b1;
        hit_cls = CLS_W'(c);
      end
    end
    open_map  = ~used_r[hit_cls] & lim[hit_cls];
    open_slot = '0;
    for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
      if (open_map[s]) begin
        open_slot = SLOT_W'(s);
      end
    end
    free_bad = ((CLS_W + 1)'(in_free_class_r) >= (CLS_W + 1)'(NUM_CLASSES)) ||
               (CNT_W'(in_free_slot_r) >= eff[in_free_class_r]) ||
               !used_r[in_free_class_r][in_free_slot_r];

    for (int c = 0; c < NUM_CLASSES; c++) begin
      used_nxt[c] = used_r[c];
    end
    grant_nxt.func   = in_func_r;
    grant_nxt.status = ST_OK;
    grant_nxt.cls    = '0;
    grant_nxt.slot   = '0;

    if (in_func_r == FUNC_ALLOC) begin
      if (!hit) begin
        grant_nxt.status = ST_NOMATCH;
      end else if (open_map == '0) begin
        grant_nxt.status = ST_FULL;
      end else begin
        grant_nxt.cls  = hit_cls;
        grant_nxt.slot = open_slot;
        if (in_vld_r) begin
          used_nxt[hit_cls][open_slot] = 1'b1;
        end
      end
    end else begin
      if (free_bad) begin
        grant_nxt.status = ST_BADFREE;
      end else begin
        grant_nxt.cls  = in_free_class_r;
        grant_nxt.slot = in_free_slot_r;
        if (in_vld_r) begin
          used_nxt[in_free_class_r][in_free_slot_r] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        used_r[c] <= '0;
      end
    end else begin
      s1_vld_r <= in_vld_r;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        used_r[c] <= used_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    grant_r <= grant_nxt;
  end

  // Offset stage
  always_comb begin
    base = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (CLS_W'(c) < grant_r.cls) begin
        base = base + prod_r[c];
      end
    end
    stride   = OFF_W'(size_r[grant_r.cls]) + OFF_W'(HEADER_BYTES);
    user_off = base + OFF_W'(grant_r.slot) * stride + OFF_W'(HEADER_BYTES);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= grant_r.status;
    if (grant_r.status == ST_OK) begin
      out_got_class_r   <= grant_r.cls;
      out_got_slot_r    <= grant_r.slot;
      out_user_offset_r <= user_off;
    end else begin
      out_got_class_r   <= '0;
      out_got_slot_r    <= '0;
      out_user_offset_r <= '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_got_class   = out_got_class_r;
  assign out_got_slot    = out_got_slot_r;
  assign out_user_offset = out_user_offset_r;

  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |=> out_valid)
    else $error("result strobe missing after decision");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_got_class == '0 && out_got_slot == '0 && out_user_offset == '0)
    else $error("failed transaction carries nonzero fields");

  a_alloc_marks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && grant_r.status == ST_OK && grant_r.func == FUNC_ALLOC |->
      used_r[grant_r.cls][grant_r.slot])
    else $error("allocated slot not marked used");

  a_free_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && grant_r.status == ST_OK && grant_r.func == FUNC_FREE |->
      !used_r[grant_r.cls][grant_r.slot])
    else $error("freed slot still marked used");

endmodule
